@@ rtl/assert_macros.svh @@
// Assertion macros for the checker file of the chunked body decoder.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion that is switched off while reset is high.
`define CHD_ASSERT(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Clocked assertion that is also checked while reset is high.
`define CHD_ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ rtl/chd_pkg.sv @@
// Package with the item types and constants of the chunked body decoder.
package chd_pkg;

  // Width of the chunk size counter.
  localparam int unsigned SIZE_BITS = 32;

  // Characters that the size line and chunk framing use.
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_X_LO  = 8'h78;
  localparam logic [7:0] CH_X_UP  = 8'h58;

  // Status codes carried with a result item.
  typedef enum logic [1:0] {
    ST_NONE  = 2'd0,
    ST_DONE  = 2'd1,
    ST_ERROR = 2'd2
  } status_t;

  // One raw body byte with its last-of-body flag.
  typedef struct packed {
    logic [7:0] body_byte;
    logic       end_of_body;
  } body_item_t;

  // One decoded result.
  typedef struct packed {
    logic       byte_valid;
    logic [7:0] out_byte;
    status_t    status;
  } result_item_t;

endpackage

@@ rtl/chd_in_reg.sv @@
// Input register stage that holds one body item for the decode step.
module chd_in_reg (
  input  logic                clk,
  input  logic                rst,
  input  logic                body_valid,
  output logic                body_ready,
  input  chd_pkg::body_item_t body_item,
  output logic                stage_valid,
  input  logic                stage_take,
  output chd_pkg::body_item_t stage_item
);

  logic                valid_q;
  chd_pkg::body_item_t item_q;

  // The stage can load when it is empty or its item leaves this cycle.
  assign body_ready  = !valid_q || stage_take;
  assign stage_valid = valid_q;
  assign stage_item  = item_q;

  // Valid flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      valid_q <= 1'b0;
    end else if (body_ready) begin
      valid_q <= body_valid;
    end
  end

  // Payload register.
  always_ff @(posedge clk) begin
    if (body_valid && body_ready) begin
      item_q <= body_item;
    end
  end

endmodule

@@ rtl/chd_core.sv @@
// Chunked framing state machine that decodes one body byte per cycle while step is high.
module chd_core (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  step,
  input  chd_pkg::body_item_t   item,
  output logic                  has_result,
  output chd_pkg::result_item_t result
);

  typedef enum logic [2:0] {
    PH_SIZE,
    PH_EXT,
    PH_LINE_CR,
    PH_DATA,
    PH_DATA_CR,
    PH_DATA_LF,
    PH_DONE,
    PH_ERR
  } phase_t;

  localparam int unsigned SB = chd_pkg::SIZE_BITS;

  phase_t                      phase, phase_next;
  logic [SB-1:0]               bytes_left, bytes_left_next;
  logic                        digit_seen, digit_seen_next;
  logic                        leading_zero_only, leading_zero_only_next;
  logic                        status_sent, status_sent_next;

  logic [7:0]                  c;
  logic                        is_hex;
  logic [3:0]                  digit;
  logic [SB-1:0]               left_dec;
  logic                        byte_valid;
  chd_pkg::status_t            status;

  assign c        = item.body_byte;
  assign left_dec = bytes_left - SB'(1);

  // Hex digit decode of the current byte.
  always_comb begin
    is_hex = 1'b1;
    digit  = 4'd0;
    if (c >= 8'h30 && c <= 8'h39) begin
      digit = 4'(c - 8'h30);
    end else if (c >= 8'h61 && c <= 8'h66) begin
      digit = 4'(c - 8'h57);
    end else if (c >= 8'h41 && c <= 8'h46) begin
      digit = 4'(c - 8'h37);
    end else begin
      is_hex = 1'b0;
    end
  end

  // Next state and result for the byte in the input stage.
  always_comb begin
    phase_next             = phase;
    bytes_left_next        = bytes_left;
    digit_seen_next        = digit_seen;
    leading_zero_only_next = leading_zero_only;
    status_sent_next       = status_sent;
    byte_valid             = 1'b0;
    status                 = chd_pkg::ST_NONE;

    unique case (phase)
      PH_SIZE: begin
        if (!digit_seen) begin
          if (c == chd_pkg::CH_SPACE || c == chd_pkg::CH_TAB) begin
            phase_next = PH_SIZE;
          end else if (is_hex) begin
            bytes_left_next        = SB'(digit);
            digit_seen_next        = 1'b1;
            leading_zero_only_next = (digit == 4'd0);
          end else begin
            status = chd_pkg::ST_ERROR;
          end
        end else if (is_hex) begin
          // A nonzero top nibble means one more digit would overflow.
          if (|bytes_left[SB-1 -: 4]) begin
            status = chd_pkg::ST_ERROR;
          end else begin
            bytes_left_next        = {bytes_left[SB-5:0], digit};
            leading_zero_only_next = 1'b0;
          end
        end else if ((c == chd_pkg::CH_X_LO || c == chd_pkg::CH_X_UP)
                     && leading_zero_only) begin
          leading_zero_only_next = 1'b0;
        end else if (c == chd_pkg::CH_CR) begin
          phase_next = PH_LINE_CR;
        end else begin
          phase_next = PH_EXT;
        end
      end
      PH_EXT: begin
        if (c == chd_pkg::CH_CR) begin
          phase_next = PH_LINE_CR;
        end
      end
      PH_LINE_CR: begin
        if (c == chd_pkg::CH_LF) begin
          digit_seen_next        = 1'b0;
          leading_zero_only_next = 1'b0;
          if (bytes_left == '0) begin
            status = chd_pkg::ST_DONE;
          end else begin
            phase_next = PH_DATA;
          end
        end else if (c != chd_pkg::CH_CR) begin
          phase_next = PH_EXT;
        end
      end
      PH_DATA: begin
        byte_valid      = 1'b1;
        bytes_left_next = left_dec;
        if (left_dec == '0) begin
          phase_next = PH_DATA_CR;
        end
      end
      PH_DATA_CR: begin
        if (c == chd_pkg::CH_CR) begin
          phase_next = PH_DATA_LF;
        end else begin
          status = chd_pkg::ST_ERROR;
        end
      end
      PH_DATA_LF: begin
        if (c == chd_pkg::CH_LF) begin
          phase_next = PH_SIZE;
        end else begin
          status = chd_pkg::ST_ERROR;
        end
      end
      PH_DONE, PH_ERR: begin
        phase_next = phase;
      end
      default: begin
        phase_next = phase;
      end
    endcase

    // A status is sent once, and the block then parks until the body ends.
    if (status == chd_pkg::ST_DONE) begin
      phase_next       = PH_DONE;
      status_sent_next = 1'b1;
    end else if (status == chd_pkg::ST_ERROR) begin
      phase_next       = PH_ERR;
      status_sent_next = 1'b1;
    end

    // The last byte of a body flags an early end unless a status was already sent, and restarts the parser.
    if (item.end_of_body) begin
      if (!status_sent_next) begin
        status = chd_pkg::ST_ERROR;
      end
      phase_next             = PH_SIZE;
      bytes_left_next        = '0;
      digit_seen_next        = 1'b0;
      leading_zero_only_next = 1'b0;
      status_sent_next       = 1'b0;
    end
  end

  assign has_result        = byte_valid || (status != chd_pkg::ST_NONE);
  assign result.byte_valid = byte_valid;
  assign result.out_byte   = byte_valid ? c : 8'h00;
  assign result.status     = status;

  // Parser state.
  always_ff @(posedge clk) begin
    if (rst) begin
      phase             <= PH_SIZE;
      bytes_left        <= '0;
      digit_seen        <= 1'b0;
      leading_zero_only <= 1'b0;
      status_sent       <= 1'b0;
    end else if (step) begin
      phase             <= phase_next;
      bytes_left        <= bytes_left_next;
      digit_seen        <= digit_seen_next;
      leading_zero_only <= leading_zero_only_next;
      status_sent       <= status_sent_next;
    end
  end

endmodule

@@ rtl/chd_out_reg.sv @@
// Result register that holds one decoded item until the receiver takes it.
module chd_out_reg (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  load,
  input  chd_pkg::result_item_t load_item,
  output logic                  can_load,
  output logic                  result_valid,
  input  logic                  result_ready,
  output chd_pkg::result_item_t result_item
);

  logic                  valid_q;
  chd_pkg::result_item_t item_q;

  // A new result fits when the register is empty or being emptied.
  assign can_load     = !valid_q || result_ready;
  assign result_valid = valid_q;
  assign result_item  = item_q;

  // Valid flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      valid_q <= 1'b0;
    end else if (load) begin
      valid_q <= 1'b1;
    end else if (result_ready) begin
      valid_q <= 1'b0;
    end
  end

  // Payload register.
  always_ff @(posedge clk) begin
    if (load) begin
      item_q <= load_item;
    end
  end

endmodule

@@ rtl/http_chunked_body_decoder.sv @@
// Top level of the HTTP/1.1 chunked transfer body decoder.
//
// Usage: raw body bytes enter on the body channel (body_valid, body_ready,
// body_item), one byte per item with an end_of_body flag on the last byte.
// Decoded results leave on the result channel (result_valid, result_ready,
// result_item): a payload byte, a done status, an error status, or a payload
// byte together with an error when the body ends early on a data byte.
// Framing bytes that produce nothing send no result item.
// A result passes through the input register and then the result register before
// it is offered; a stalled receiver can hold the byte in the input register.
// Throughput: one byte per cycle, sustained while the receiver does not stall;
// the framing state machine takes one step per cycle, and the state it leaves
// is needed by the next byte. Reset (rst, synchronous) empties both registers
// and puts the parser at the start of a chunk-size line. The same restart
// happens after every byte that carries end_of_body.
// When the receiver stalls, the result register holds its item; the input
// register still takes one more byte, and body_ready then falls until the
// result is taken.
module http_chunked_body_decoder (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  body_valid,
  output logic                  body_ready,
  input  chd_pkg::body_item_t   body_item,
  output logic                  result_valid,
  input  logic                  result_ready,
  output chd_pkg::result_item_t result_item
);

  logic                  stage_valid;
  logic                  stage_take;
  chd_pkg::body_item_t   stage_item;
  logic                  can_load;
  logic                  has_result;
  chd_pkg::result_item_t core_result;

  // A held byte is decoded when the result register has room.
  assign stage_take = stage_valid && can_load;

  chd_in_reg u_in_reg (
    .clk         (clk),
    .rst         (rst),
    .body_valid  (body_valid),
    .body_ready  (body_ready),
    .body_item   (body_item),
    .stage_valid (stage_valid),
    .stage_take  (stage_take),
    .stage_item  (stage_item)
  );

  chd_core u_core (
    .clk        (clk),
    .rst        (rst),
    .step       (stage_take),
    .item       (stage_item),
    .has_result (has_result),
    .result     (core_result)
  );

  chd_out_reg u_out_reg (
    .clk          (clk),
    .rst          (rst),
    .load         (stage_take && has_result),
    .load_item    (core_result),
    .can_load     (can_load),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result_item  (result_item)
  );

endmodule

@@ rtl/chd_checker.sv @@
// Port-level checker for the chunked body decoder, bound to the top level.
`include "assert_macros.svh"

module chd_checker (
  input logic                  clk,
  input logic                  rst,
  input logic                  body_valid,
  input logic                  body_ready,
  input chd_pkg::body_item_t   body_item,
  input logic                  result_valid,
  input logic                  result_ready,
  input chd_pkg::result_item_t result_item
);

  // Reset empties the result register.
  `CHD_ASSERT_ALWAYS(a_reset_empties, clk, rst |=> !result_valid, "result valid after reset")

  // A stalled result stays offered and unchanged.
  `CHD_ASSERT(a_result_hold, clk, rst, result_valid && !result_ready |=> result_valid && $stable(result_item), "stalled result changed")

  // Every result item carries a byte or a status.
  `CHD_ASSERT(a_result_nonempty, clk, rst, result_valid |-> result_item.byte_valid || result_item.status != chd_pkg::ST_NONE, "empty result item")

  // A payload byte never comes with the done status.
  `CHD_ASSERT(a_byte_not_done, clk, rst, result_valid && result_item.byte_valid |-> result_item.status != chd_pkg::ST_DONE, "payload byte with done status")

  // A result without a payload byte shows a zero byte.
  `CHD_ASSERT(a_idle_byte_zero, clk, rst, result_valid && !result_item.byte_valid |-> result_item.out_byte == 8'h00, "nonzero byte without byte_valid")

endmodule

bind http_chunked_body_decoder chd_checker u_chd_checker (.*);

@@ dv/tb.sv @@
// Testbench for the chunked body decoder: a directed table, then random chunked bodies.
`timescale 1ns / 1ps

module tb;

  localparam int STALL_LIMIT  = 2000;
  localparam int DRAIN_CYCLES = 12;
  localparam int RANDOM_ITEMS = 1700;

  // Parser phases of the decoder model.
  typedef enum logic [2:0] {
    P_SIZE, P_EXT, P_LINE_CR, P_DATA, P_DATA_CR, P_DATA_LF, P_DONE, P_ERR
  } parse_phase_t;

  // Receiver stall patterns.
  typedef enum logic [1:0] {
    RX_STEADY, RX_COIN, RX_SPARSE
  } rx_mode_t;

  // One stimulus row: the byte, its flag, and an optional hand-written result.
  typedef struct packed {
    logic [7:0]       b;
    logic             eob;
    logic             typed;
    logic             has;
    logic             v;
    logic [7:0]       ob;
    chd_pkg::status_t st;
  } stim_row_t;

  // Directed bodies: no digit, zero-size body then a byte after done, a prefix,
  // a lone CR and a missing chunk terminator, an early end on a data byte, and
  // a prefix with no digits.
  localparam stim_row_t DIRECTED_ROWS [24] = '{
    '{8'hFF,            1'b1, 1'b1, 1'b1, 1'b0, 8'h00,         chd_pkg::ST_ERROR},
    '{"0",              1'b0, 1'b0, 1'b0, 1'b0, 8'h00,         chd_pkg::ST_NONE},
    '{chd_pkg::CH_CR,   1'b0, 1'b0, 1'b0, 1'b0, 8'h00,         chd_pkg::ST_NONE},
    '{chd_pkg::CH_LF,   1'b0, 1'b1, 1'b1, 1'b0, 8'h00,         chd_pkg::ST_DONE},
    '{8'h00,            1'b1, 1'b1, 1'b0, 1'b0, 8'h00,         chd_pkg::ST_NONE},
    '{"0",              1'b0, 1'b0, 1'b0, 1'b0, 8'h00,         chd_pkg::ST_NONE},
    '{chd_pkg::CH_X_UP, 1'b0, 1'b0, 1'b0, 1'b0, 8'h00,         chd_pkg::ST_NONE},
    '{"1",              1'b0, 1'b0, 1'b0, 1'b0, 8'h00,         chd_pkg::ST_NONE},
    '{chd_pkg::CH_CR,   1'b0, 1'b0, 1'b0, 1'b0, 8'h00,         chd_pkg::ST_NONE},
    '{8'h00,            1'b0, 1'b0, 1'b0, 1'b0, 8'h00,         chd_pkg::ST_NONE},
    '{chd_pkg::CH_CR,   1'b0, 1'b0, 1'b0, 1'b0, 8'h00,         chd_pkg::ST_NONE},
    '{chd_pkg::CH_LF,   1'b0, 1'b0, 1'b0, 1'b0, 8'h00,         chd_pkg::ST_NONE},
    '{chd_pkg::CH_CR,   1'b0, 1'b1, 1'b1, 1'b1, chd_pkg::CH_CR, chd_pkg::ST_NONE},
    '{"Z",              1'b0, 1'b1, 1'b1, 1'b0, 8'h00,         chd_pkg::ST_ERROR},
    '{"Q",              1'b1, 1'b1, 1'b0, 1'b0, 8'h00,         chd_pkg::ST_NONE},
    '{"1",              1'b0, 1'b0, 1'b0, 1'b0, 8'h00,         chd_pkg::ST_NONE},
    '{chd_pkg::CH_CR,   1'b0, 1'b0, 1'b0, 1'b0, 8'h00,         chd_pkg::ST_NONE},
    '{chd_pkg::CH_LF,   1'b0, 1'b0, 1'b0, 1'b0, 8'h00,         chd_pkg::ST_NONE},
    '{8'hA5,            1'b1, 1'b1, 1'b1, 1'b1, 8'hA5,         chd_pkg::ST_ERROR},
    '{"0",              1'b0, 1'b0, 1'b0, 1'b0, 8'h00,         chd_pkg::ST_NONE},
    '{chd_pkg::CH_X_LO, 1'b0, 1'b0, 1'b0, 1'b0, 8'h00,         chd_pkg::ST_NONE},
    '{";",              1'b0, 1'b0, 1'b0, 1'b0, 8'h00,         chd_pkg::ST_NONE},
    '{chd_pkg::CH_CR,   1'b0, 1'b0, 1'b0, 1'b0, 8'h00,         chd_pkg::ST_NONE},
    '{chd_pkg::CH_LF,   1'b1, 1'b1, 1'b1, 1'b0, 8'h00,         chd_pkg::ST_DONE}
  };

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  body_valid = 1'b0;
  logic                  body_ready;
  chd_pkg::body_item_t   body_item = '0;
  logic                  result_valid;
  logic                  result_ready = 1'b0;
  chd_pkg::result_item_t result_item;

  // Decoder model state.
  parse_phase_t                  parse_phase;
  logic [chd_pkg::SIZE_BITS-1:0] size_left;
  logic                          digit_seen;
  logic                          zero_only;
  logic                          status_sent;

  stim_row_t             rows[$];
  logic [7:0]            body_buf[$];
  chd_pkg::result_item_t expected_results[$];
  stim_row_t             cur_row;
  int                    row_idx;
  int                    burst_left;
  int                    gap_left;
  int                    fail_count = 0;
  int                    idle_cycles;
  int                    rx_cycle;
  int                    hold_left;
  rx_mode_t              rx_mode;

  http_chunked_body_decoder u_dut (
    .clk          (clk),
    .rst          (rst),
    .body_valid   (body_valid),
    .body_ready   (body_ready),
    .body_item    (body_item),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result_item  (result_item)
  );

  always #1 clk = ~clk;

  // Put the model parser back at the start of a size line.
  task automatic clear_parser();
    parse_phase = P_SIZE;
    size_left   = '0;
    digit_seen  = 1'b0;
    zero_only   = 1'b0;
    status_sent = 1'b0;
  endtask

  // Advance the model by one body byte and return the result it causes.
  task automatic decode_byte(input chd_pkg::body_item_t it, output bit has_res,
                             output chd_pkg::result_item_t res);
    logic [7:0]       c;
    logic [3:0]       nib;
    bit               is_hex;
    bit               v;
    chd_pkg::status_t st;
    c      = it.body_byte;
    v      = 1'b0;
    st     = chd_pkg::ST_NONE;
    is_hex = 1'b1;
    nib    = '0;
    if (c >= "0" && c <= "9") nib = 4'(c - "0");
    else if (c >= "a" && c <= "f") nib = 4'(c - "a" + 8'd10);
    else if (c >= "A" && c <= "F") nib = 4'(c - "A" + 8'd10);
    else is_hex = 1'b0;

    case (parse_phase)
      P_SIZE: begin
        if (!digit_seen) begin
          // Blanks before the first digit are skipped; anything else is an error.
          if (c != chd_pkg::CH_SPACE && c != chd_pkg::CH_TAB) begin
            if (is_hex) begin
              size_left  = chd_pkg::SIZE_BITS'(nib);
              digit_seen = 1'b1;
              zero_only  = (nib == 4'd0);
            end else begin
              st = chd_pkg::ST_ERROR;
            end
          end
        end else if (is_hex) begin
          if (size_left[chd_pkg::SIZE_BITS-1 -: 4] != 4'd0) begin
            st = chd_pkg::ST_ERROR;
          end else begin
            size_left = {size_left[chd_pkg::SIZE_BITS-5:0], nib};
            zero_only = 1'b0;
          end
        end else if ((c == chd_pkg::CH_X_LO || c == chd_pkg::CH_X_UP) && zero_only) begin
          zero_only = 1'b0;
        end else if (c == chd_pkg::CH_CR) begin
          parse_phase = P_LINE_CR;
        end else begin
          parse_phase = P_EXT;
        end
      end
      P_EXT: begin
        if (c == chd_pkg::CH_CR) parse_phase = P_LINE_CR;
      end
      P_LINE_CR: begin
        if (c == chd_pkg::CH_LF) begin
          digit_seen = 1'b0;
          zero_only  = 1'b0;
          if (size_left == '0) st = chd_pkg::ST_DONE;
          else parse_phase = P_DATA;
        end else if (c != chd_pkg::CH_CR) begin
          parse_phase = P_EXT;
        end
      end
      P_DATA: begin
        v         = 1'b1;
        size_left = size_left - chd_pkg::SIZE_BITS'(1);
        if (size_left == '0) parse_phase = P_DATA_CR;
      end
      P_DATA_CR: begin
        if (c == chd_pkg::CH_CR) parse_phase = P_DATA_LF;
        else st = chd_pkg::ST_ERROR;
      end
      P_DATA_LF: begin
        if (c == chd_pkg::CH_LF) parse_phase = P_SIZE;
        else st = chd_pkg::ST_ERROR;
      end
      default: ;
    endcase

    if (st == chd_pkg::ST_DONE) begin
      parse_phase = P_DONE;
      status_sent = 1'b1;
    end
    if (st == chd_pkg::ST_ERROR) begin
      parse_phase = P_ERR;
      status_sent = 1'b1;
    end
    // The last byte of a body ends it: an error unless a status already went out.
    if (it.end_of_body) begin
      if (!status_sent) st = chd_pkg::ST_ERROR;
      clear_parser();
    end

    has_res         = v || (st != chd_pkg::ST_NONE);
    res.byte_valid  = v;
    res.out_byte    = v ? c : 8'h00;
    res.status      = st;
  endtask

  function automatic logic [7:0] hex_char(input logic [3:0] n, input bit upper);
    if (n < 4'd10) return "0" + 8'(n);
    return (upper ? "A" : "a") + 8'(n) - 8'd10;
  endfunction

  // Append one byte to the body being built.
  task automatic put_byte(input logic [7:0] b);
    body_buf.insert(body_buf.size(), b);
  endtask

  // Append one chunk-size line with random blanks, prefix, leading zeros and extension.
  task automatic put_size_line(input logic [31:0] value);
    int         top;
    int         i;
    bit         prefixed;
    logic [7:0] r;
    repeat ($urandom_range(0, 2))
      put_byte($urandom_range(0, 1) ? chd_pkg::CH_SPACE : chd_pkg::CH_TAB);
    prefixed = ($urandom_range(0, 3) == 0);
    if (prefixed) begin
      put_byte("0");
      put_byte($urandom_range(0, 1) ? chd_pkg::CH_X_UP : chd_pkg::CH_X_LO);
    end
    top = 0;
    for (i = 0; i < 8; i++) if (value[4*i +: 4] != 4'd0) top = i;
    // A prefix may stand alone for a zero size.
    if (!(prefixed && value == 0 && $urandom_range(0, 1) == 1)) begin
      repeat ($urandom_range(0, 2)) put_byte("0");
      for (i = top; i >= 0; i--)
        put_byte(hex_char(value[4*i +: 4], 1'($urandom_range(0, 1))));
    end
    // Extension text; a CR inside it is followed by a printable byte, never LF.
    if ($urandom_range(0, 1) == 1) begin
      put_byte(";");
      repeat ($urandom_range(0, 4)) begin
        r = 8'($urandom_range(0, 255));
        put_byte(r);
        if (r == chd_pkg::CH_CR) put_byte(8'($urandom_range(8'h20, 8'h7E)));
      end
    end
    put_byte(chd_pkg::CH_CR);
    put_byte(chd_pkg::CH_LF);
  endtask

  // Build one random body and append it as stimulus rows.
  task automatic build_body();
    int         kind;
    int         n_chunks;
    int         k;
    int         i;
    int         cut;
    int         sz;
    logic [7:0] r;
    stim_row_t  row;
    body_buf.delete();
    kind = $urandom_range(0, 9);
    if (kind == 0) begin
      // Noise.
      repeat ($urandom_range(1, 12)) put_byte(8'($urandom_range(0, 255)));
    end else if (kind == 1) begin
      // Size line that overflows the counter on its ninth digit.
      put_byte(hex_char(4'($urandom_range(1, 15)), 1'($urandom_range(0, 1))));
      repeat (8) put_byte(hex_char(4'($urandom_range(0, 15)), 1'($urandom_range(0, 1))));
      put_byte(chd_pkg::CH_CR);
      put_byte(chd_pkg::CH_LF);
    end else begin
      n_chunks = $urandom_range(0, 3);
      for (k = 0; k < n_chunks; k++) begin
        sz = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 64) : $urandom_range(1, 8);
        put_size_line(32'(sz));
        repeat (sz) put_byte(8'($urandom_range(0, 255)));
        if (kind == 2 && k == n_chunks - 1) begin
          // Broken chunk terminator: bad CR or bad LF.
          if ($urandom_range(0, 1) == 1) begin
            put_byte(chd_pkg::CH_CR);
            do r = 8'($urandom_range(0, 255)); while (r == chd_pkg::CH_LF);
          end else begin
            do r = 8'($urandom_range(0, 255)); while (r == chd_pkg::CH_CR);
          end
          put_byte(r);
        end else begin
          put_byte(chd_pkg::CH_CR);
          put_byte(chd_pkg::CH_LF);
        end
      end
      put_size_line(32'd0);
      // Trailer bytes after done are ignored.
      if ($urandom_range(0, 2) == 0)
        repeat ($urandom_range(1, 6)) put_byte(8'($urandom_range(0, 255)));
      if (kind == 3) begin
        body_buf[$urandom_range(0, body_buf.size() - 1)] = 8'($urandom_range(0, 255));
      end else if (kind == 4) begin
        cut = $urandom_range(1, body_buf.size());
        while (body_buf.size() > cut) void'(body_buf.pop_back());
      end
    end
    for (i = 0; i < body_buf.size(); i++) begin
      row     = '0;
      row.b   = body_buf[i];
      row.eob = (i == body_buf.size() - 1);
      rows.insert(rows.size(), row);
    end
  endtask

  // Result check, model update on each accepted byte, and the byte sender.
  always @(posedge clk) begin : drive_and_check
    bit                    has_res;
    chd_pkg::result_item_t res;
    chd_pkg::result_item_t want;
    if (rst) begin
      body_valid <= 1'b0;
      body_item  <= '0;
      row_idx    = 0;
      burst_left = 0;
      gap_left   = 0;
      clear_parser();
      expected_results.delete();
    end else begin
      if (result_valid && result_ready) begin
        if (expected_results.size() == 0) begin
          $display("%0t: result expected none, actual %h", $time, result_item);
          fail_count++;
        end else begin
          want = expected_results.pop_front();
          if (result_item.byte_valid !== want.byte_valid) begin
            $display("%0t: byte_valid expected %0b actual %0b", $time,
                     want.byte_valid, result_item.byte_valid);
            fail_count++;
          end
          if (result_item.out_byte !== want.out_byte) begin
            $display("%0t: out_byte expected %02h actual %02h", $time,
                     want.out_byte, result_item.out_byte);
            fail_count++;
          end
          if (result_item.status !== want.status) begin
            $display("%0t: status expected %0d actual %0d", $time,
                     want.status, result_item.status);
            fail_count++;
          end
        end
      end

      if (body_valid && body_ready) begin
        decode_byte('{body_byte: cur_row.b, end_of_body: cur_row.eob}, has_res, res);
        if (cur_row.typed) begin
          has_res        = cur_row.has;
          res.byte_valid = cur_row.v;
          res.out_byte   = cur_row.ob;
          res.status     = cur_row.st;
        end
        if (has_res) expected_results.insert(expected_results.size(), res);
      end

      // Offer bytes in bursts with gaps; one stretch runs with no gaps at all.
      if (!body_valid || body_ready) begin
        if (gap_left > 0) begin
          gap_left--;
          body_valid <= 1'b0;
        end else if (row_idx < rows.size()) begin
          cur_row = rows[row_idx];
          row_idx++;
          body_item  <= '{body_byte: cur_row.b, end_of_body: cur_row.eob};
          body_valid <= 1'b1;
          if (burst_left > 0) begin
            burst_left--;
          end else begin
            burst_left = $urandom_range(1, 40);
            gap_left   = (row_idx >= 600 && row_idx < 900) ? 0 : $urandom_range(0, 6);
          end
        end else begin
          body_valid <= 1'b0;
        end
      end
    end
  end

  // Receiver stalls: a pattern that is drawn anew at a regular interval, and one long hold-off.
  always @(posedge clk) begin
    if (rst) begin
      result_ready <= 1'b0;
      rx_cycle  = 0;
      hold_left = 0;
      rx_mode   = RX_STEADY;
    end else begin
      rx_cycle++;
      if (rx_cycle == 1000) hold_left = 150;
      if (rx_cycle % 256 == 0) rx_mode = rx_mode_t'($urandom_range(0, 2));
      if (hold_left > 0) begin
        hold_left--;
        result_ready <= 1'b0;
      end else begin
        case (rx_mode)
          RX_STEADY: result_ready <= 1'b1;
          RX_COIN:   result_ready <= 1'($urandom_range(0, 1));
          default:   result_ready <= ($urandom_range(0, 7) != 0);
        endcase
      end
    end
  end

  // Watchdog on cycles in which neither channel moves an item.
  always @(posedge clk) begin
    if (rst) begin
      idle_cycles = 0;
    end else if ((body_valid && body_ready) || (result_valid && result_ready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("CHECKS FAILED");
        $finish;
      end
    end
  end

  initial begin : run
    foreach (DIRECTED_ROWS[i]) rows.insert(rows.size(), DIRECTED_ROWS[i]);
    while (rows.size() < RANDOM_ITEMS + 24) build_body();

    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // Wait until every byte is taken and every result has come back.
    do @(negedge clk);
    while (!(row_idx == rows.size() && !body_valid && expected_results.size() == 0));
    repeat (DRAIN_CYCLES) @(negedge clk);

    if (fail_count == 0 && expected_results.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
+incdir+rtl
rtl/chd_pkg.sv
rtl/chd_in_reg.sv
rtl/chd_core.sv
rtl/chd_out_reg.sv
rtl/http_chunked_body_decoder.sv
rtl/chd_checker.sv
dv/tb.sv
